@@ design/plc_pkg.sv @@
// Shared types, constants and helpers for the piecewise-linear calibration block.
// No dependencies; compile first.
package plc_pkg;

  localparam int unsigned MaxPoints = 16;
  localparam int unsigned IdxW      = $clog2(MaxPoints);
  localparam int unsigned CntW      = $clog2(MaxPoints + 1);
  localparam int unsigned XW        = 26;
  localparam int unsigned YW        = 26;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned XDivW     = 17;
  localparam int unsigned YDivW     = 17;
  localparam int unsigned MagW      = SampleW + YW;
  localparam int unsigned DvdW      = MagW + 10;
  localparam int unsigned VW        = DvdW + 2;
  localparam int unsigned DivCntW   = $clog2(DvdW);

  localparam int unsigned RecipShift = 36;
  localparam logic [26:0] Recip1000  = 27'd68719477;
  localparam logic [9:0]  Unit1000   = 10'd1000;

  localparam logic [XW-1:0] Mask26     = '1;
  localparam logic [YW-1:0] RangeHighRst = 26'd500;

  localparam logic [1:0] FUNC_CLEAR   = 2'd0;
  localparam logic [1:0] FUNC_LOAD    = 2'd1;
  localparam logic [1:0] FUNC_MEASURE = 2'd2;

  localparam logic CFG_RANGE_LOW  = 1'b0;
  localparam logic CFG_RANGE_HIGH = 1'b1;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_LOAD,
    OP_MEASURE,
    OP_NOP
  } op_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_NONRISING = 2'd2
  } status_e;

  typedef struct packed {
    op_e                op;
    logic [XW-1:0]      px;
    logic [YW-1:0]      py;
    logic [SampleW-1:0] sample;
  } qent_t;

  function automatic logic [XDivW-1:0] div1000(input logic [XW-1:0] v);
    logic [XW+27-1:0] prod;
    prod = 53'(v) * 53'(Recip1000);
    return prod[RecipShift +: XDivW];
  endfunction

endpackage

@@ design/plc_if.sv @@
// Channel interfaces for the calibration block: input items and result items.
// Depends on plc_pkg for field widths.
interface plc_in_if;
  import plc_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [XW-1:0]      point_x;
  logic [YW-1:0]      point_y;
  logic [SampleW-1:0] sample;
  modport source(output valid, func, point_x, point_y, sample, input ready);
  modport sink(input valid, func, point_x, point_y, sample, output ready);
endinterface

interface plc_out_if;
  import plc_pkg::*;
  logic          valid;
  logic          ready;
  logic [1:0]    status;
  logic [YW-1:0] result_milli;
  logic          out_of_range;
  modport source(output valid, status, result_milli, out_of_range, input ready);
  modport sink(input valid, status, result_milli, out_of_range, output ready);
endinterface

@@ design/plc_front.sv @@
// Front end: accepts input items, classifies the function code, pushes to the queue.
// Depends on plc_pkg and plc_in_if.
module plc_front import plc_pkg::*; (
  plc_in_if.sink item_i,
  input  logic   q_full_i,
  output logic   push_o,
  output qent_t  push_data_o
);

  op_e op;

  always_comb begin
    case (item_i.func)
      FUNC_CLEAR:   op = OP_CLEAR;
      FUNC_LOAD:    op = OP_LOAD;
      FUNC_MEASURE: op = OP_MEASURE;
      default:      op = OP_NOP;
    endcase
  end

  assign item_i.ready       = !q_full_i;
  assign push_o             = item_i.valid && !q_full_i;
  assign push_data_o.op     = op;
  assign push_data_o.px     = item_i.point_x;
  assign push_data_o.py     = item_i.point_y;
  assign push_data_o.sample = item_i.sample;

endmodule

@@ design/plc_queue.sv @@
// Two-entry queue between the front end and the execution back end.
// Depends on plc_pkg.
module plc_queue import plc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  qent_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  avail_o,
  output qent_t pop_data_o
);

  qent_t      mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o     = cnt_q == 2'd2;
  assign avail_o    = cnt_q != 2'd0;
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q ^ push_i;
    rd_d  = rd_q ^ pop_i;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

@@ design/plc_back.sv @@
// Back end: breakpoint table, sequential search, interpolation with a bit-serial
// divider, range check and output register. Depends on plc_pkg and plc_out_if.
module plc_back import plc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          avail_i,
  input  qent_t         ent_i,
  output logic          pop_o,
  input  logic [YW-1:0] range_low_i,
  input  logic [YW-1:0] range_high_i,
  plc_out_if.source     result_o
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_SEARCH  = 9'b000000010,
    S_RND_DIV = 9'b000000100,
    S_RND_MUL = 9'b000001000,
    S_MUL_T   = 9'b000010000,
    S_MUL_K   = 9'b000100000,
    S_DIVIDE  = 9'b001000000,
    S_COMBINE = 9'b010000000,
    S_FINISH  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [XW-1:0] x_mem [MaxPoints];
  logic [YW-1:0] y_mem [MaxPoints];

  logic [CntW-1:0]    count_q, j_q;
  logic [XW-1:0]      last_x_q, xp_q, dx_q;
  logic [XDivW-1:0]   xpd_q;
  logic [YW-1:0]      yp_q, yr_q, dymag_q;
  logic               neg_q;
  logic [YDivW-1:0]   yq_q;
  logic [SampleW-1:0] sample_q, t_q;
  logic [MagW-1:0]    mag_q;
  logic [DvdW-1:0]    dvd_q;
  logic [XW-1:0]      rem_q;
  logic [DivCntW-1:0] dcnt_q;
  logic signed [VW-1:0] v_q;

  logic          out_vld_q;
  logic [1:0]    status_q;
  logic [YW-1:0] res_q;
  logic          oor_q;

  logic          slot_free;
  logic [XW-1:0] xj, yj;
  logic [XDivW-1:0] xjd;
  logic [XW:0]   rsh, rdiff;
  logic [XDivW-1:0] tw;
  logic          v_neg, v_big, v_lo, v_hi;

  assign slot_free = !out_vld_q || result_o.ready;
  assign pop_o     = (state_q == S_IDLE) && avail_i && slot_free;

  assign xj  = (j_q == '0) ? '0 : x_mem[j_q[IdxW-1:0]];
  assign yj  = (j_q == '0) ? '0 : y_mem[j_q[IdxW-1:0]];
  assign xjd = div1000(xj);
  assign tw  = XDivW'(sample_q) - xpd_q;

  assign rsh   = {rem_q, dvd_q[DvdW-1]};
  assign rdiff = rsh - {1'b0, dx_q};

  assign v_neg = v_q < 0;
  assign v_big = v_q > $signed(VW'(Mask26));
  assign v_lo  = v_q < $signed(VW'(range_low_i));
  assign v_hi  = v_q > $signed(VW'(range_high_i));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (pop_o && ent_i.op == OP_MEASURE) begin
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (j_q == count_q) begin
          state_d = S_RND_DIV;
        end else if (XDivW'(sample_q) <= xjd) begin
          state_d = (j_q == '0) ? S_RND_DIV : S_MUL_T;
        end
      end
      S_RND_DIV: state_d = S_RND_MUL;
      S_RND_MUL: state_d = S_FINISH;
      S_MUL_T:   state_d = S_MUL_K;
      S_MUL_K:   state_d = S_DIVIDE;
      S_DIVIDE: begin
        if (dcnt_q == '0) begin
          state_d = S_COMBINE;
        end
      end
      S_COMBINE: state_d = S_FINISH;
      S_FINISH: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= CntW'(1);
      last_x_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (pop_o && ent_i.op != OP_MEASURE) begin
        out_vld_q <= 1'b1;
        if (ent_i.op == OP_CLEAR) begin
          count_q  <= CntW'(1);
          last_x_q <= '0;
        end else if (ent_i.op == OP_LOAD && count_q != CntW'(MaxPoints)
                     && ent_i.px > last_x_q) begin
          count_q  <= count_q + CntW'(1);
          last_x_q <= ent_i.px;
        end
      end
      if (state_q == S_FINISH && slot_free) begin
        out_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && ent_i.op == OP_LOAD && count_q != CntW'(MaxPoints)
        && ent_i.px > last_x_q) begin
      x_mem[count_q[IdxW-1:0]] <= ent_i.px;
      y_mem[count_q[IdxW-1:0]] <= ent_i.py;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        sample_q <= ent_i.sample;
        j_q      <= '0;
        if (pop_o) begin
          status_q <= STS_OK;
          res_q    <= '0;
          oor_q    <= 1'b0;
          if (ent_i.op == OP_LOAD) begin
            if (count_q == CntW'(MaxPoints)) begin
              status_q <= STS_FULL;
            end else if (ent_i.px <= last_x_q) begin
              status_q <= STS_NONRISING;
            end
          end
        end
      end
      S_SEARCH: begin
        if (j_q == count_q) begin
          yr_q <= yp_q;
        end else if (XDivW'(sample_q) <= xjd) begin
          yr_q    <= yj;
          t_q     <= tw[SampleW-1:0];
          dx_q    <= xj - xp_q;
          neg_q   <= yj < yp_q;
          dymag_q <= (yj < yp_q) ? (yp_q - yj) : (yj - yp_q);
        end else begin
          xp_q  <= xj;
          xpd_q <= xjd;
          yp_q  <= yj;
          j_q   <= j_q + CntW'(1);
        end
      end
      S_RND_DIV: yq_q <= div1000(yr_q);
      S_RND_MUL: v_q  <= $signed(VW'(yq_q) * VW'(Unit1000));
      S_MUL_T:   mag_q <= MagW'(t_q) * MagW'(dymag_q);
      S_MUL_K: begin
        dvd_q  <= DvdW'(mag_q) * DvdW'(Unit1000);
        rem_q  <= '0;
        dcnt_q <= DivCntW'(DvdW - 1);
      end
      S_DIVIDE: begin
        dcnt_q <= dcnt_q - DivCntW'(1);
        if (!rdiff[XW]) begin
          rem_q <= rdiff[XW-1:0];
          dvd_q <= {dvd_q[DvdW-2:0], 1'b1};
        end else begin
          rem_q <= rsh[XW-1:0];
          dvd_q <= {dvd_q[DvdW-2:0], 1'b0};
        end
      end
      S_COMBINE: begin
        v_q <= neg_q ? ($signed(VW'(yp_q)) - $signed(VW'(dvd_q)))
                     : ($signed(VW'(yp_q)) + $signed(VW'(dvd_q)));
      end
      S_FINISH: begin
        if (slot_free) begin
          status_q <= STS_OK;
          res_q    <= v_neg ? '0 : (v_big ? Mask26 : v_q[YW-1:0]);
          oor_q    <= v_lo || v_hi;
        end
      end
      default: ;
    endcase
  end

  assign result_o.valid        = out_vld_q;
  assign result_o.status       = status_q;
  assign result_o.result_milli = res_q;
  assign result_o.out_of_range = oor_q;

endmodule

@@ design/piecewise_linear_calibration.sv @@
// Piecewise-linear calibration engine: clear and load are done in the back end's idle
// state; measure runs the search (one breakpoint a cycle) and then either rounds the
// table-end point (divide, multiply, finish) or interpolates (multiply, scale by 1000,
// bit-serial divide, combine, finish). The back end takes one item at a time.
// A two-entry queue lets the front accept while the back end works.
// Reset (async, active low) leaves one (0,0) point and range [0, 500].
module piecewise_linear_calibration import plc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  plc_in_if.sink        item_i,
  plc_out_if.source     result_o,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [YW-1:0] cfg_data_i
);

  logic [YW-1:0] range_low_q, range_high_q;
  logic          q_full, push, pop, avail;
  qent_t         push_data, pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q  <= '0;
      range_high_q <= RangeHighRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_RANGE_LOW) begin
        range_low_q <= cfg_data_i;
      end
      if (cfg_idx_i == CFG_RANGE_HIGH) begin
        range_high_q <= cfg_data_i;
      end
    end
  end

  plc_front u_front (
    .item_i      (item_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  plc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .avail_o     (avail),
    .pop_data_o  (pop_data)
  );

  plc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .avail_i      (avail),
    .ent_i        (pop_data),
    .pop_o        (pop),
    .range_low_i  (range_low_q),
    .range_high_i (range_high_q),
    .result_o     (result_o)
  );

endmodule
